// ===== rtl/core/sdrj_pkg.sv =====
// ----------------------------------------------------------------------------
// sdrj_pkg
// Shared widths, character codes and the job record for the decimal formatter.
// ----------------------------------------------------------------------------
package sdrj_pkg;

  localparam int VALUE_W       = 32;  // width of the signed input value
  localparam int WIDTH_IN_W    = 6;   // width of the field_width input
  localparam int FIELD_W       = 7;   // holds any field size up to 64
  localparam int NDIG          = 10;  // decimal digits of a 32-bit magnitude
  localparam int DIG_W         = 4;   // one BCD digit
  localparam int NDIG_W        = 4;   // digit count / digit index
  localparam int CHAR_W        = 8;
  localparam int MAX_FIELD_DEF = 32;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // One converted value, ready to be printed.
  typedef struct packed {
    logic [NDIG-1:0][DIG_W-1:0] digits;  // BCD, digit 0 least significant
    logic                       neg;
    logic [NDIG_W-1:0]          ndig;    // significant digits, 1 to 10
    logic [FIELD_W-1:0]         pad;     // leading spaces
  } sdrj_job_t;

endpackage

// ===== rtl/core/signed_decimal_right_justify.sv =====
// ----------------------------------------------------------------------------
// signed_decimal_right_justify
// Signed 32-bit integer to right-justified decimal ASCII, one character per
// output item.
// ----------------------------------------------------------------------------
// Each input item carries a signed value and a field width; the block emits
// the value as decimal text, most significant character first, preceded by
// enough spaces to fill the field (widths above MAX_FIELD saturate there, and
// text longer than the field is never cut). Zero prints as "0", a negative
// value carries a leading '-', and the most negative value prints correctly.
// tlast marks the final digit; it is never set on a padding space. The front
// end accepts a value, converts it (binary-to-BCD, one bit a cycle) and hands
// it over, and takes no new value until the handover is done. The back end
// then emits one character a cycle while the output is not stalled, max(field,
// text length) characters per value. A two-entry queue lets conversion of the
// next value overlap the printing of the current one. No state survives
// between items.
module signed_decimal_right_justify #(
  parameter int MAX_FIELD = sdrj_pkg::MAX_FIELD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] value, [37:32] field_width, [39:38] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] character
  output logic        m_axis_tlast    // last_char
);
  import sdrj_pkg::*;

  sdrj_job_t front_job;
  sdrj_job_t back_job;
  logic      front_valid;
  logic      q_full;
  logic      q_not_empty;
  logic      back_ready;

  // Front end: accept and convert.
  sdrj_front #(
    .MAX_FIELD (MAX_FIELD)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .value       (s_axis_tdata[VALUE_W-1:0]),
    .field_width (s_axis_tdata[VALUE_W+WIDTH_IN_W-1:VALUE_W]),
    .job_valid   (front_valid),
    .job_ready   (!q_full),
    .job         (front_job)
  );

  // Decouple conversion from printing.
  sdrj_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .full      (q_full),
    .wr_job    (front_job),
    .pop       (back_ready),
    .not_empty (q_not_empty),
    .rd_job    (back_job)
  );

  // Back end: print padding, sign and digits.
  sdrj_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_not_empty),
    .job_ready (back_ready),
    .job       (back_job),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .character (m_axis_tdata),
    .last_char (m_axis_tlast)
  );

  // The final character of any text is always a digit.
  a_last_is_digit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata >= CH_ZERO) && (m_axis_tdata <= CH_NINE))
    else $error("final character is not a digit");

  // Once an item is taken, the front end is busy converting.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted again during conversion");

  // A padding space is never flagged as the end of the text.
  a_space_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata == CH_SPACE) |-> !m_axis_tlast)
    else $error("space marked as last character");

endmodule

// ===== rtl/core/sdrj_front.sv =====
// ----------------------------------------------------------------------------
// sdrj_front
// Accept an item, convert its magnitude to BCD by shift-and-add-3, one bit a
// cycle, and work out digit count and padding.
// ----------------------------------------------------------------------------
module sdrj_front #(
  parameter int MAX_FIELD = sdrj_pkg::MAX_FIELD_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sdrj_pkg::VALUE_W-1:0]    value,
  input  logic [sdrj_pkg::WIDTH_IN_W-1:0] field_width,
  output logic                            job_valid,
  input  logic                            job_ready,
  output sdrj_pkg::sdrj_job_t             job
);
  import sdrj_pkg::*;

  localparam int CNT_W = $clog2(VALUE_W);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_DONE = 3'b100
  } fstate_t;

  fstate_t                    state;
  logic [CNT_W-1:0]           cnt;
  logic [VALUE_W-1:0]         mag;
  logic [NDIG-1:0][DIG_W-1:0] bcd;
  logic                       neg;
  logic [FIELD_W-1:0]         width;

  logic [NDIG-1:0][DIG_W-1:0] bcd_adj;
  logic [NDIG_W-1:0]          ndig;
  logic [NDIG_W-1:0]          text_len;
  logic [FIELD_W-1:0]         text_len_x;
  logic [FIELD_W-1:0]         width_in;

  assign in_ready  = (state == S_IDLE);
  assign job_valid = (state == S_DONE);
  assign width_in  = FIELD_W'(field_width);

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i] = (bcd[i] >= DIG_W'(5)) ? bcd[i] + DIG_W'(3) : bcd[i];
    end
  end

  always_comb begin
    ndig = NDIG_W'(1);
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i] != '0) ndig = NDIG_W'(i + 1);
    end
  end

  assign text_len   = ndig + NDIG_W'(neg);
  assign text_len_x = FIELD_W'(text_len);

  always_comb begin
    job.digits = bcd;
    job.neg    = neg;
    job.ndig   = ndig;
    job.pad    = (width > text_len_x) ? width - text_len_x : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CONV;
            cnt   <= '0;
          end
        end
        S_CONV: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(VALUE_W - 1)) state <= S_DONE;
        end
        S_DONE: begin
          if (job_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath: load on accept, shift while converting.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      neg   <= value[VALUE_W-1];
      mag   <= value[VALUE_W-1] ? VALUE_W'(0) - value : value;
      bcd   <= '0;
      width <= (width_in > FIELD_W'(MAX_FIELD)) ? FIELD_W'(MAX_FIELD) : width_in;
    end else if (state == S_CONV) begin
      {bcd, mag} <= {bcd_adj[NDIG-1:0], mag} << 1;
    end
  end

endmodule

// ===== rtl/core/sdrj_queue.sv =====
// ----------------------------------------------------------------------------
// sdrj_queue
// Two-entry queue of converted jobs between conversion and printing.
// ----------------------------------------------------------------------------
module sdrj_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  sdrj_pkg::sdrj_job_t wr_job,
  input  logic                pop,
  output logic                not_empty,
  output sdrj_pkg::sdrj_job_t rd_job
);
  import sdrj_pkg::*;

  sdrj_job_t  entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_job    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== rtl/core/sdrj_back.sv =====
// ----------------------------------------------------------------------------
// sdrj_back
// Take one job at a time and print it: spaces, optional sign, then digits
// most significant first, through a registered output stage.
// ----------------------------------------------------------------------------
module sdrj_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_valid,
  output logic                          job_ready,
  input  sdrj_pkg::sdrj_job_t           job,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sdrj_pkg::CHAR_W-1:0]   character,
  output logic                          last_char
);
  import sdrj_pkg::*;

  logic                       active;
  logic [FIELD_W-1:0]         pad_cnt;
  logic                       sign_pend;
  logic [NDIG_W-1:0]          dig_idx;
  logic [NDIG-1:0][DIG_W-1:0] digits;

  logic                       advance;
  logic [CHAR_W-1:0]          char_next;
  logic                       last_next;

  assign job_ready = !active;
  assign advance   = active && (!out_valid || out_ready);

  always_comb begin
    last_next = 1'b0;
    if (pad_cnt != '0) begin
      char_next = CH_SPACE;
    end else if (sign_pend) begin
      char_next = CH_MINUS;
    end else begin
      char_next = CH_ZERO + CHAR_W'(digits[dig_idx]);
      last_next = (dig_idx == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!active && job_valid) begin
        active <= 1'b1;
      end else if (advance && last_next) begin
        active <= 1'b0;
      end
      if (!out_valid || out_ready) out_valid <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (!active && job_valid) begin
      pad_cnt   <= job.pad;
      sign_pend <= job.neg;
      dig_idx   <= job.ndig - NDIG_W'(1);
      digits    <= job.digits;
    end else if (advance) begin
      if (pad_cnt != '0) begin
        pad_cnt <= pad_cnt - FIELD_W'(1);
      end else if (sign_pend) begin
        sign_pend <= 1'b0;
      end else if (dig_idx != '0) begin
        dig_idx <= dig_idx - NDIG_W'(1);
      end
    end
    if (advance) begin
      character <= char_next;
      last_char <= last_next;
    end
  end

endmodule
